FILE: hw/rtl/mssp_pkg.sv
// Shared types and constants of the mid/side stereo processor.
package mssp_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int GAIN_FRAC_BITS_DEF = 12;

    localparam int MID_GAIN_W    = 16;
    localparam int SIDE_GAIN_W   = 17;
    localparam int BALANCE_W     = 14;
    localparam int WET_MIX_W     = 13;
    localparam int OUTPUT_GAIN_W = 14;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    typedef struct packed {
        logic [MID_GAIN_W-1:0]       mid_gain;
        logic [SIDE_GAIN_W-1:0]      side_gain;
        logic signed [BALANCE_W-1:0] balance;
        logic [WET_MIX_W-1:0]        wet_mix;
        logic [OUTPUT_GAIN_W-1:0]    output_gain;
        logic                        bypass;
        logic                        mono_mode;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul_ms;
        logic pan;
        logic mul_bal;
        logic rnd_bal;
        logic mul_wet;
        logic mix;
        logic mul_out;
        logic finish;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

FILE: hw/rtl/mssp_cfg_regs.sv
// Configuration register file of the mid/side stereo processor.
module mssp_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mssp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mssp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mssp_pkg::cfg_t                    cfg
);
    import mssp_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_MID_GAIN    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SIDE_GAIN   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_BALANCE     = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX     = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] REG_BYPASS      = CFG_INDEX_W'(5);
    localparam logic [CFG_INDEX_W-1:0] REG_MONO_MODE   = CFG_INDEX_W'(6);

    localparam cfg_t CFG_RESET = '{
        mid_gain:    MID_GAIN_W'(4096),
        side_gain:   SIDE_GAIN_W'(4096),
        balance:     '0,
        wet_mix:     WET_MIX_W'(4096),
        output_gain: OUTPUT_GAIN_W'(4096),
        bypass:      1'b0,
        mono_mode:   1'b0
    };

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MID_GAIN:    cfg_reg.mid_gain    <= cfg_data[MID_GAIN_W-1:0];
                REG_SIDE_GAIN:   cfg_reg.side_gain   <= cfg_data[SIDE_GAIN_W-1:0];
                REG_BALANCE:     cfg_reg.balance     <= cfg_data[BALANCE_W-1:0];
                REG_WET_MIX:     cfg_reg.wet_mix     <= cfg_data[WET_MIX_W-1:0];
                REG_OUTPUT_GAIN: cfg_reg.output_gain <= cfg_data[OUTPUT_GAIN_W-1:0];
                REG_BYPASS:      cfg_reg.bypass      <= cfg_data[0];
                REG_MONO_MODE:   cfg_reg.mono_mode   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/mssp_ctrl.sv
// Step sequencer of the mid/side stereo processor.
module mssp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mssp_pkg::cfg_t       cfg,
    input  mssp_pkg::dp_status_t status,
    output mssp_pkg::dp_cmd_t    cmd
);
    import mssp_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_MUL_MS  = 10'b0000000010,
        ST_PAN     = 10'b0000000100,
        ST_MUL_BAL = 10'b0000001000,
        ST_RND_BAL = 10'b0000010000,
        ST_MUL_WET = 10'b0000100000,
        ST_MIX     = 10'b0001000000,
        ST_MUL_OUT = 10'b0010000000,
        ST_FINISH  = 10'b0100000000,
        ST_EMIT    = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (cfg.bypass)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (cfg.mono_mode)
                    begin
                        state_next = ST_MUL_OUT;
                    end
                    else
                    begin
                        state_next = ST_MUL_MS;
                    end
                end
            end
            ST_MUL_MS:
            begin
                cmd.mul_ms = 1'b1;
                state_next = ST_PAN;
            end
            ST_PAN:
            begin
                cmd.pan    = 1'b1;
                state_next = ST_MUL_BAL;
            end
            ST_MUL_BAL:
            begin
                cmd.mul_bal = 1'b1;
                state_next  = ST_RND_BAL;
            end
            ST_RND_BAL:
            begin
                cmd.rnd_bal = 1'b1;
                state_next  = ST_MUL_WET;
            end
            ST_MUL_WET:
            begin
                cmd.mul_wet = 1'b1;
                state_next  = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = ST_MUL_OUT;
            end
            ST_MUL_OUT:
            begin
                cmd.mul_out = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/mssp_datapath.sv
// Arithmetic datapath, peak meters and output register of the mid/side stereo processor.
module mssp_datapath #(
    parameter int SAMPLE_BITS    = mssp_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = mssp_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mssp_pkg::dp_cmd_t             cmd,
    input  mssp_pkg::cfg_t                cfg,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  logic                          last_in_block,
    output mssp_pkg::dp_status_t          status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic [SAMPLE_BITS-1:0]        input_peak,
    output logic [SAMPLE_BITS-1:0]        output_peak,
    output logic                          block_done
);
    import mssp_pkg::*;

    localparam int SW    = SAMPLE_BITS;
    localparam int FB    = GAIN_FRAC_BITS;
    localparam int PL_W  = SW + SIDE_GAIN_W - FB + 2;
    localparam int WL_W  = PL_W + 1;
    localparam int ML_W  = PL_W + 2;
    localparam int MA_W  = ML_W;
    localparam int MB_W  = (SIDE_GAIN_W + 1 > FB + 3) ? SIDE_GAIN_W + 1 : FB + 3;
    localparam int P_W   = MA_W + MB_W;
    localparam int X_W   = P_W + 1;
    localparam int G_W   = FB + 2;
    localparam int K_W   = FB + 1;
    localparam int BG_W  = ((BALANCE_W > FB + 2) ? BALANCE_W : FB + 2) + 1;
    localparam int WT_W  = (WET_MIX_W > FB + 1) ? WET_MIX_W : FB + 1;

    localparam logic signed [BG_W-1:0] ZERO_B = BG_W'(0);
    localparam logic signed [BG_W-1:0] ONE_B = BG_W'(2 ** FB);
    localparam logic signed [BG_W-1:0] TWO_B = BG_W'(2 ** (FB + 1));
    localparam logic [WT_W-1:0]        ONE_W = WT_W'(2 ** FB);
    localparam logic signed [X_W-1:0]  SMAX_X = X_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [X_W-1:0]  SMIN_X = X_W'(-(64'sd1 <<< (SW - 1)));

    function automatic logic signed [X_W-1:0] rnd(input logic signed [X_W-1:0] x,
                                                  input int unsigned k);
        logic signed [X_W-1:0] h;
        logic signed [X_W-1:0] n;
        h        = '0;
        n        = '0;
        h[k - 1] = 1'b1;
        n[0]     = x[X_W-1];
        rnd      = (x + h - n) >>> k;
    endfunction

    function automatic logic signed [SW-1:0] sat(input logic signed [X_W-1:0] x);
        logic signed [X_W-1:0] y;
        y = x;
        if (x > SMAX_X)
        begin
            y = SMAX_X;
        end
        else if (x < SMIN_X)
        begin
            y = SMIN_X;
        end
        sat = SW'(y);
    endfunction

    function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] x);
        mag = x[SW-1] ? (~x + 1'b1) : x;
    endfunction

    logic signed [SW-1:0]   l_reg;
    logic signed [SW-1:0]   r_reg;
    logic                   last_reg;
    logic signed [SW:0]     sum_reg;
    logic signed [SW:0]     diff_reg;
    logic signed [P_W-1:0]  prod0_reg;
    logic signed [P_W-1:0]  prod1_reg;
    logic signed [P_W-1:0]  dl_reg;
    logic signed [P_W-1:0]  dr_reg;
    logic signed [PL_W-1:0] pl_reg;
    logic signed [PL_W-1:0] pr_reg;
    logic signed [WL_W-1:0] wl_reg;
    logic signed [WL_W-1:0] wr_reg;
    logic signed [ML_W-1:0] ml_reg;
    logic signed [ML_W-1:0] mr_reg;
    logic signed [SW-1:0]   ol_reg;
    logic signed [SW-1:0]   or_reg;
    logic [SW-1:0]          ipk_reg;
    logic [SW-1:0]          in_acc_reg;
    logic [SW-1:0]          out_acc_reg;
    logic                   out_valid_reg;
    logic signed [SW-1:0]   lo_reg;
    logic signed [SW-1:0]   ro_reg;
    logic [SW-1:0]          ipo_reg;
    logic [SW-1:0]          opo_reg;
    logic                   done_reg;

    logic signed [SW-1:0]   right_eff;
    logic signed [BG_W-1:0] bal_x;
    logic signed [BG_W-1:0] lg_x;
    logic signed [BG_W-1:0] rg_x;
    logic [G_W-1:0]         lg;
    logic [G_W-1:0]         rg;
    logic [WT_W-1:0]        wet_x;
    logic [K_W-1:0]         wet;
    logic [K_W-1:0]         dry;
    logic signed [MA_W-1:0] mul_a0;
    logic signed [MA_W-1:0] mul_a1;
    logic signed [MB_W-1:0] mul_b0;
    logic signed [MB_W-1:0] mul_b1;
    logic signed [P_W-1:0]  mul0;
    logic signed [P_W-1:0]  mul1;
    logic                   mul_en;
    logic [SW-1:0]          ipk_now;
    logic [SW-1:0]          opk_now;
    logic [SW-1:0]          ol_mag;
    logic [SW-1:0]          or_mag;
    logic [SW-1:0]          l_mag;
    logic [SW-1:0]          r_mag;
    logic [SW-1:0]          in_acc_new;
    logic [SW-1:0]          out_acc_new;

    assign right_eff = cfg.mono_mode ? '0 : right_sample;

    // Balance and mix gains follow straight from the configuration registers.
    always_comb
    begin
        bal_x = BG_W'($signed(cfg.balance));
        lg_x  = ONE_B - ((bal_x > ZERO_B) ? bal_x : ZERO_B);
        rg_x  = ONE_B + ((bal_x < ZERO_B) ? bal_x : ZERO_B);
        if (lg_x < ZERO_B)
        begin
            lg = '0;
        end
        else if (lg_x > TWO_B)
        begin
            lg = G_W'(TWO_B);
        end
        else
        begin
            lg = G_W'(lg_x);
        end
        if (rg_x < ZERO_B)
        begin
            rg = '0;
        end
        else if (rg_x > TWO_B)
        begin
            rg = G_W'(TWO_B);
        end
        else
        begin
            rg = G_W'(rg_x);
        end
        wet_x = (WT_W'(cfg.wet_mix) > ONE_W) ? ONE_W : WT_W'(cfg.wet_mix);
        wet   = K_W'(wet_x);
        dry   = K_W'(ONE_W - wet_x);
    end

    always_comb
    begin
        mul_a0 = '0;
        mul_b0 = '0;
        mul_a1 = '0;
        mul_b1 = '0;
        if (cmd.mul_ms)
        begin
            mul_a0 = MA_W'(sum_reg);
            mul_b0 = MB_W'($signed({1'b0, cfg.mid_gain}));
            mul_a1 = MA_W'(diff_reg);
            mul_b1 = MB_W'($signed({1'b0, cfg.side_gain}));
        end
        else if (cmd.pan)
        begin
            mul_a0 = MA_W'(l_reg);
            mul_b0 = MB_W'($signed({1'b0, dry}));
            mul_a1 = MA_W'(r_reg);
            mul_b1 = MB_W'($signed({1'b0, dry}));
        end
        else if (cmd.mul_bal)
        begin
            mul_a0 = MA_W'(pl_reg);
            mul_b0 = MB_W'($signed({1'b0, lg}));
            mul_a1 = MA_W'(pr_reg);
            mul_b1 = MB_W'($signed({1'b0, rg}));
        end
        else if (cmd.mul_wet)
        begin
            mul_a0 = MA_W'(wl_reg);
            mul_b0 = MB_W'($signed({1'b0, wet}));
            mul_a1 = MA_W'(wr_reg);
            mul_b1 = MB_W'($signed({1'b0, wet}));
        end
        else if (cmd.mul_out)
        begin
            mul_a0 = cfg.mono_mode ? MA_W'(l_reg) : ml_reg;
            mul_b0 = MB_W'($signed({1'b0, cfg.output_gain}));
            mul_a1 = mr_reg;
            mul_b1 = MB_W'($signed({1'b0, cfg.output_gain}));
        end
    end

    assign mul0   = mul_a0 * mul_b0;
    assign mul1   = mul_a1 * mul_b1;
    assign mul_en = cmd.mul_ms | cmd.pan | cmd.mul_bal | cmd.mul_wet | cmd.mul_out;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            l_reg    <= left_sample;
            r_reg    <= right_eff;
            last_reg <= last_in_block;
            sum_reg  <= (SW + 1)'(left_sample) + (SW + 1)'(right_eff);
            diff_reg <= (SW + 1)'(left_sample) - (SW + 1)'(right_eff);
        end
        if (mul_en)
        begin
            prod0_reg <= mul0;
            prod1_reg <= mul1;
        end
        if (cmd.pan)
        begin
            pl_reg <= PL_W'(rnd(X_W'(prod0_reg) + X_W'(prod1_reg), FB + 1));
            pr_reg <= PL_W'(rnd(X_W'(prod0_reg) - X_W'(prod1_reg), FB + 1));
        end
        if (cmd.mul_bal)
        begin
            dl_reg <= prod0_reg;
            dr_reg <= prod1_reg;
        end
        if (cmd.rnd_bal)
        begin
            wl_reg <= WL_W'(rnd(X_W'(prod0_reg), FB));
            wr_reg <= WL_W'(rnd(X_W'(prod1_reg), FB));
        end
        if (cmd.mix)
        begin
            ml_reg <= ML_W'(rnd(X_W'(dl_reg) + X_W'(prod0_reg), FB));
            mr_reg <= ML_W'(rnd(X_W'(dr_reg) + X_W'(prod1_reg), FB));
        end
        if (cmd.finish)
        begin
            ipk_reg <= ipk_now;
            if (cfg.bypass)
            begin
                ol_reg <= l_reg;
                or_reg <= r_reg;
            end
            else
            begin
                ol_reg <= sat(rnd(X_W'(prod0_reg), FB));
                or_reg <= cfg.mono_mode ? '0 : sat(rnd(X_W'(prod1_reg), FB));
            end
        end
        if (cmd.emit)
        begin
            lo_reg   <= ol_reg;
            ro_reg   <= or_reg;
            ipo_reg  <= in_acc_new;
            opo_reg  <= out_acc_new;
            done_reg <= last_reg;
        end
    end

    assign l_mag       = mag(l_reg);
    assign r_mag       = mag(r_reg);
    assign ipk_now     = (l_mag > r_mag) ? l_mag : r_mag;
    assign ol_mag      = mag(ol_reg);
    assign or_mag      = mag(or_reg);
    assign opk_now     = (ol_mag > or_mag) ? ol_mag : or_mag;
    assign in_acc_new  = (ipk_reg > in_acc_reg) ? ipk_reg : in_acc_reg;
    assign out_acc_new = (opk_now > out_acc_reg) ? opk_now : out_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_acc_reg    <= '0;
            out_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                in_acc_reg    <= last_reg ? '0 : in_acc_new;
                out_acc_reg   <= last_reg ? '0 : out_acc_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_busy = out_valid_reg & ~out_ready;
    assign out_valid       = out_valid_reg;
    assign left_out        = lo_reg;
    assign right_out       = ro_reg;
    assign input_peak      = ipo_reg;
    assign output_peak     = opo_reg;
    assign block_done      = done_reg;

endmodule

FILE: hw/rtl/mid_side_stereo_processor_core.sv
// Top level of the mid/side stereo width processor with block peak metering.
// One stereo frame is taken per transaction on the input stream and gives one
// result transaction. The controller steps each frame through the two shared
// multipliers of the datapath and takes no new frame before the last is emitted;
// mono mode goes straight to the output gain step and bypass skips every
// multiplier step. A result still held by the output register stalls the emit.
// Gains are linear fixed-point values with GAIN_FRAC_BITS fraction bits; every
// rescale rounds half away from zero and the outputs saturate to SAMPLE_BITS.
// The peaks report the running maximum magnitude over the current metering
// block and restart after a frame with tlast set. Configuration is to be written
// only while no frame is in flight; the block itself does not enforce this.
module mid_side_stereo_processor_core #(
    parameter int SAMPLE_BITS    = mssp_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = mssp_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // left_sample, right_sample
    input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    input  logic                                        s_axis_tlast,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // left_out, right_out, input_peak, output_peak
    output logic [((4 * SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
    output logic                                        m_axis_tlast,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [mssp_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [mssp_pkg::CFG_DATA_W-1:0]             cfg_data
);
    import mssp_pkg::*;

    localparam int SW    = SAMPLE_BITS;
    localparam int OUT_W = ((4 * SAMPLE_BITS + 7) / 8) * 8;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    logic signed [SW-1:0] left_sample;
    logic signed [SW-1:0] right_sample;
    logic signed [SW-1:0] left_out;
    logic signed [SW-1:0] right_out;
    logic [SW-1:0]        input_peak;
    logic [SW-1:0]        output_peak;

    assign left_sample  = s_axis_tdata[SW-1:0];
    assign right_sample = s_axis_tdata[2*SW-1:SW];
    assign m_axis_tdata = OUT_W'({output_peak, input_peak, right_out, left_out});

    mssp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mssp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cfg      (cfg),
        .status   (status),
        .cmd      (cmd)
    );

    mssp_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .last_in_block (s_axis_tlast),
        .status        (status),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .left_out      (left_out),
        .right_out     (right_out),
        .input_peak    (input_peak),
        .output_peak   (output_peak),
        .block_done    (m_axis_tlast)
    );

endmodule
